// ===== sv/bounded_stack_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack with search
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH

// same-cycle implication
`define BSWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bsws_pkg.sv =====
// ----------------------------------------------------------------------------
// bsws_pkg
// Sizes, request, status and state codes used by the stack; its RAM gets its sizes as parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package bsws_pkg;

	localparam int DEPTH  = 8;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 3;
	localparam int FILL_W = 4;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_SRCH = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== sv/bsws_ram.sv =====
// ----------------------------------------------------------------------------
// bsws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/bounded_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// Fixed-depth LIFO of 32-bit words held in a RAM, with push, pop and a
// top-down search for the topmost matching entry.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  request   start, taken when !busy  req_type, value
//  result    done, one-cycle strobe   status, data_out, found_index,
//                                     fill_count, empty_flag, full_flag
//
//  Push, no-op and any refused request: busy stays low, result in the next cycle.
//  Pop: one RAM read, busy while in S_POP, result registered out of S_POP.
//  Search: one RAM read per entry from the top, busy while in S_SRCH.
//  Reset clears the fill count and control; RAM contents are not cleared.
//  The receiver cannot stall; done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_with_search_assert.svh"

module bounded_stack_with_search (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic        [bsws_pkg::REQ_W-1:0]   req_type,
	input  wire logic signed [bsws_pkg::DATA_W-1:0]  value,
	output logic                                     done,
	output logic             [bsws_pkg::STAT_W-1:0]  status,
	output logic signed      [bsws_pkg::DATA_W-1:0]  data_out,
	output logic             [bsws_pkg::IDX_W-1:0]   found_index,
	output logic             [bsws_pkg::FILL_W-1:0]  fill_count,
	output logic                                     empty_flag,
	output logic                                     full_flag
);

	import bsws_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_m1;
	logic [ADDR_W-1:0]   idx_q, idx_d;
	logic [DATA_W-1:0]   key_q, key_d;

	logic                we;
	logic [ADDR_W-1:0]   raddr;
	logic [DATA_W-1:0]   rdata;

	logic                emit;
	status_t             res_status;
	logic [DATA_W-1:0]   res_data;
	logic [ADDR_W-1:0]   res_idx;
	logic                cnt_empty, cnt_full;
	logic                push_go;

	logic                done_q;
	status_t             status_q;
	logic [DATA_W-1:0]   data_q;
	logic [IDX_W-1:0]    fidx_q;
	logic [FILL_W-1:0]   fill_q;
	logic                empty_q, full_q;

	assign cnt_m1    = cnt_q - 1'b1;
	assign cnt_empty = (cnt_q == '0);
	assign cnt_full  = (cnt_q == CNT_W'(DEPTH));
	assign push_go   = start && !busy && (req_t'(req_type) == REQ_PUSH) && !cnt_full;

	bsws_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		key_d      = key_q;
		we         = 1'b0;
		raddr      = cnt_m1[ADDR_W-1:0];
		emit       = 1'b0;
		res_status = ST_OK;
		res_data   = '0;
		res_idx    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					key_d = value;
					unique case (req_t'(req_type))
						REQ_PUSH: begin
							emit = 1'b1;
							if (cnt_full) begin
								res_status = ST_OVERFLOW;
							end else begin
								we    = 1'b1;
								cnt_d = cnt_q + 1'b1;
							end
						end
						REQ_POP: begin
							if (cnt_empty) begin
								emit       = 1'b1;
								res_status = ST_UNDERFLOW;
								res_data   = '1;
							end else begin
								// top entry read issued now, data lands in S_POP
								cnt_d   = cnt_m1;
								state_d = S_POP;
							end
						end
						REQ_SEARCH: begin
							if (cnt_empty) begin
								emit       = 1'b1;
								res_status = ST_NOT_FOUND;
							end else begin
								idx_d   = cnt_m1[ADDR_W-1:0];
								state_d = S_SRCH;
							end
						end
						REQ_NOP: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				emit     = 1'b1;
				res_data = rdata;
				state_d  = S_IDLE;
			end
			S_SRCH: begin
				// rdata holds entry idx_q; prefetch the one below
				raddr = idx_q - 1'b1;
				if (rdata == key_q) begin
					emit    = 1'b1;
					res_idx = idx_q;
					state_d = S_IDLE;
				end else if (idx_q == '0) begin
					emit       = 1'b1;
					res_status = ST_NOT_FOUND;
					state_d    = S_IDLE;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		key_q <= key_d;
		if (emit) begin
			status_q <= res_status;
			data_q   <= res_data;
			fidx_q   <= IDX_W'(res_idx);
			fill_q   <= FILL_W'(cnt_d);
			empty_q  <= (cnt_d == '0);
			full_q   <= (cnt_d == CNT_W'(DEPTH));
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign data_out    = $signed(data_q);
	assign found_index = fidx_q;
	assign fill_count  = fill_q;
	assign empty_flag  = empty_q;
	assign full_flag   = full_q;

	`BSWS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(DEPTH), "fill count beyond depth")
	`BSWS_ASSERT_NOW(a_srch_idx, state_q == S_SRCH, CNT_W'(idx_q) < cnt_q, "search index above top")
	`BSWS_ASSERT_NEXT(a_pop_one, state_q == S_POP, state_q == S_IDLE && done_q, "pop result missing")
	`BSWS_ASSERT_NEXT(a_push_cnt, push_go, cnt_q == $past(cnt_q) + 1'b1, "push did not grow stack")

endmodule

`default_nettype wire
